>>> design/i2cram_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// i2cram_pkg
// Shared types and codes for the I2C register access master.
// ---------------------------------------------------------------------------
package i2cram_pkg;

  // Command codes carried in the action field
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_PROBE = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  // Transaction status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_ACK  = 2'd1;
  localparam logic [1:0] ST_INV_ARG = 2'd2;

  // Longest read accepted in one transaction
  localparam logic [2:0] MAX_READ_BYTES = 3'd4;

  // Target address after reset
  localparam logic [6:0] DEV_ADDR_RESET = 7'h6d;

  // One bus quantum request
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] reg_addr;
    logic [7:0] wdata;
    logic [2:0] read_len;
    logic       sda_in;
  } item_t;

  // Line drive and flags for one quantum
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       byte_valid;
    logic [7:0] rdata;
    logic       done_res;
    logic [1:0] status;
  } res_t;

endpackage : i2cram_pkg
`default_nettype wire

>>> design/i2cram_in_reg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// i2cram_in_reg
// Input register: holds one request until the sequencer takes it.
// ---------------------------------------------------------------------------
module i2cram_in_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire i2cram_pkg::item_t in_item,
  input  wire logic             take,
  output logic                  held_valid,
  output i2cram_pkg::item_t     held_item
);

  logic load;

  assign in_stall = held_valid & ~take;
  assign load     = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_item <= in_item;
    end
  end

endmodule : i2cram_in_reg
`default_nettype wire

>>> design/i2cram_seq.sv
`default_nettype none
// ---------------------------------------------------------------------------
// i2cram_seq
// Bus sequencer: advances one quantum per request, drives SCL/SDA.
// ---------------------------------------------------------------------------
module i2cram_seq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire i2cram_pkg::item_t item,
  input  wire logic [6:0]        device_addr,
  output i2cram_pkg::res_t       res
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_START1, PH_ADDR_W, PH_REG, PH_VALUE,
    PH_START2, PH_ADDR_R, PH_READ, PH_STOP_OK, PH_STOP_NACK
  } phase_t;

  phase_t     phase, phase_next, target;
  logic [1:0] tick_step, tick_step_next;
  logic [2:0] bit_count, bit_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [2:0] bytes_left, bytes_left_next;
  logic [1:0] command_kind, command_kind_next;
  logic [7:0] latched_reg, latched_reg_next;
  logic [7:0] latched_value, latched_value_next;
  logic [1:0] line_drive, line_drive_next;
  logic       in_ack_slot, in_ack_slot_next;
  logic       ack_seen, ack_seen_next;
  logic       enter;
  logic       scl, sda;

  always_comb begin
    phase_next         = phase;
    tick_step_next     = tick_step;
    bit_count_next     = bit_count;
    shift_byte_next    = shift_byte;
    bytes_left_next    = bytes_left;
    command_kind_next  = command_kind;
    latched_reg_next   = latched_reg;
    latched_value_next = latched_value;
    line_drive_next    = line_drive;
    in_ack_slot_next   = in_ack_slot;
    ack_seen_next      = ack_seen;
    enter              = 1'b0;
    target             = PH_IDLE;
    scl                = line_drive[1];
    sda                = line_drive[0];
    res                = '0;

    // command start, only from idle
    if (phase == PH_IDLE && item.action != i2cram_pkg::ACT_TICK) begin
      if (item.action == i2cram_pkg::ACT_READ &&
          (item.read_len == 3'd0 || item.read_len > i2cram_pkg::MAX_READ_BYTES)) begin
        res.done_res = 1'b1;
        res.status   = i2cram_pkg::ST_INV_ARG;
      end else begin
        command_kind_next  = item.action;
        latched_reg_next   = item.reg_addr;
        latched_value_next = item.wdata;
        bytes_left_next    = (item.action == i2cram_pkg::ACT_READ) ? item.read_len : 3'd0;
        phase_next         = PH_START1;
        tick_step_next     = 2'd0;
        bit_count_next     = 3'd7;
        in_ack_slot_next   = 1'b0;
        ack_seen_next      = 1'b0;
        shift_byte_next    = 8'd0;
      end
    end

    if (phase_next != PH_IDLE) begin
      res.busy_res = 1'b1;
      case (phase_next)
        PH_START1, PH_START2: begin
          scl = (tick_step_next < 2'd2);
          sda = (tick_step_next == 2'd0);
          if (tick_step_next == 2'd2) begin
            enter  = 1'b1;
            target = (phase_next == PH_START1) ? PH_ADDR_W : PH_ADDR_R;
          end else begin
            tick_step_next = tick_step_next + 2'd1;
          end
        end
        PH_STOP_OK, PH_STOP_NACK: begin
          scl = (tick_step_next != 2'd0);
          sda = (tick_step_next == 2'd2);
          if (tick_step_next == 2'd2) begin
            res.done_res = 1'b1;
            res.status   = (phase_next == PH_STOP_NACK) ? i2cram_pkg::ST_NO_ACK
                                                        : i2cram_pkg::ST_OK;
            enter  = 1'b1;
            target = PH_IDLE;
          end else begin
            tick_step_next = tick_step_next + 2'd1;
          end
        end
        default: begin
          scl = (tick_step_next == 2'd1);
          if (!in_ack_slot_next) begin
            if (phase_next == PH_READ) begin
              sda = 1'b1;
              if (tick_step_next == 2'd1) begin
                shift_byte_next = {shift_byte_next[6:0], item.sda_in};
                if (bit_count_next == 3'd0) begin
                  res.byte_valid = 1'b1;
                  res.rdata      = shift_byte_next;
                end
              end
            end else begin
              sda = shift_byte_next[bit_count_next];
            end
            if (tick_step_next == 2'd2) begin
              tick_step_next = 2'd0;
              if (bit_count_next == 3'd0) begin
                in_ack_slot_next = 1'b1;
              end else begin
                bit_count_next = bit_count_next - 3'd1;
              end
            end else begin
              tick_step_next = tick_step_next + 2'd1;
            end
          end else begin
            // ACK slot: master acks all but the last read byte
            if (phase_next == PH_READ) begin
              sda = ~(tick_step_next != 2'd2 && bytes_left_next > 3'd1);
            end else begin
              sda = 1'b1;
              if (tick_step_next == 2'd1) begin
                ack_seen_next = ~item.sda_in;
              end
            end
            if (tick_step_next == 2'd2) begin
              enter = 1'b1;
              if (phase_next == PH_READ) begin
                if (bytes_left_next != 3'd0) begin
                  bytes_left_next = bytes_left_next - 3'd1;
                end
                target = (bytes_left_next == 3'd0) ? PH_STOP_OK : PH_READ;
              end else if (!ack_seen_next) begin
                target = PH_STOP_NACK;
              end else begin
                case (phase_next)
                  PH_ADDR_W: target = (command_kind_next == i2cram_pkg::ACT_PROBE)
                                      ? PH_STOP_OK : PH_REG;
                  PH_REG:    target = (command_kind_next == i2cram_pkg::ACT_WRITE)
                                      ? PH_VALUE : PH_START2;
                  PH_VALUE:  target = PH_STOP_OK;
                  default:   target = PH_READ;
                endcase
              end
            end else begin
              tick_step_next = tick_step_next + 2'd1;
            end
          end
        end
      endcase
      line_drive_next = {scl, sda};
    end

    // next phase entry: reset counters and load the byte to send
    if (enter) begin
      phase_next       = target;
      tick_step_next   = 2'd0;
      bit_count_next   = 3'd7;
      in_ack_slot_next = 1'b0;
      ack_seen_next    = 1'b0;
      case (target)
        PH_ADDR_W: shift_byte_next = {device_addr, 1'b0};
        PH_ADDR_R: shift_byte_next = {device_addr, 1'b1};
        PH_REG:    shift_byte_next = latched_reg_next;
        PH_VALUE:  shift_byte_next = latched_value_next;
        default:   shift_byte_next = 8'd0;
      endcase
    end

    res.scl_out = scl;
    res.sda_out = sda;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_step     <= 2'd0;
      bit_count     <= 3'd7;
      shift_byte    <= 8'd0;
      bytes_left    <= 3'd0;
      command_kind  <= i2cram_pkg::ACT_TICK;
      latched_reg   <= 8'd0;
      latched_value <= 8'd0;
      line_drive    <= 2'b11;
      in_ack_slot   <= 1'b0;
      ack_seen      <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      tick_step     <= tick_step_next;
      bit_count     <= bit_count_next;
      shift_byte    <= shift_byte_next;
      bytes_left    <= bytes_left_next;
      command_kind  <= command_kind_next;
      latched_reg   <= latched_reg_next;
      latched_value <= latched_value_next;
      line_drive    <= line_drive_next;
      in_ack_slot   <= in_ack_slot_next;
      ack_seen      <= ack_seen_next;
    end
  end

endmodule : i2cram_seq
`default_nettype wire

>>> design/i2cram_out_reg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// i2cram_out_reg
// Result register: holds one result request until the sink takes it.
// ---------------------------------------------------------------------------
module i2cram_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             held_valid,
  input  wire i2cram_pkg::res_t res_in,
  output logic                  take,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output i2cram_pkg::res_t      res_out
);

  // free when empty or being drained this cycle
  assign take = held_valid & (~out_valid | ~out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_out <= res_in;
    end
  end

endmodule : i2cram_out_reg
`default_nettype wire

>>> design/i2c_register_access_master_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// i2c_register_access_master_core
// I2C master for probe, register write and register read over open-drain
// SCL/SDA, one bus quantum (a third of a bit period) per input request.
// ---------------------------------------------------------------------------
// Path: the input register holds the request, then the sequencer step lands
// in the result register.
// Throughput: one request per cycle; the sequencer takes one quantum step
// per cycle, limited only by stall on the result side.
// Reset: synchronous, active high; sequencer idle with both line drives released
// (result register contents not reset), device_addr back to 0x6d, both pipeline registers empty.
// ---------------------------------------------------------------------------
module i2c_register_access_master_core (
  input  wire logic       clk,
  input  wire logic       rst,
  // input requests
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] action,
  input  wire logic [7:0] reg_addr,
  input  wire logic [7:0] wdata,
  input  wire logic [2:0] read_len,
  input  wire logic       sda_in,
  // result requests
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            scl_out,
  output logic            sda_out,
  output logic            busy_res,
  output logic            byte_valid,
  output logic [7:0]      rdata,
  output logic            done_res,
  output logic [1:0]      status,
  // device address register
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [6:0] cfg_data
);

  i2cram_pkg::item_t in_item;
  i2cram_pkg::item_t held_item;
  i2cram_pkg::res_t  step_res;
  i2cram_pkg::res_t  res_q;
  logic              held_valid;
  logic              take;
  logic [6:0]        device_addr;

  assign in_item.action   = action;
  assign in_item.reg_addr = reg_addr;
  assign in_item.wdata    = wdata;
  assign in_item.read_len = read_len;
  assign in_item.sda_in   = sda_in;

  // Config writes must only land while idle; the block does not enforce it and is always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_addr <= i2cram_pkg::DEV_ADDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      device_addr <= cfg_data;
    end
  end

  // Stage 1: capture the request
  i2cram_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // Sequencer: one bus quantum per taken request; state moves with take
  i2cram_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .step        (take),
    .item        (held_item),
    .device_addr (device_addr),
    .res         (step_res)
  );

  // Stage 2: result register towards the sink
  i2cram_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .res_in     (step_res),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res_out    (res_q)
  );

  assign scl_out    = res_q.scl_out;
  assign sda_out    = res_q.sda_out;
  assign busy_res   = res_q.busy_res;
  assign byte_valid = res_q.byte_valid;
  assign rdata      = res_q.rdata;
  assign done_res   = res_q.done_res;
  assign status     = res_q.status;

endmodule : i2c_register_access_master_core
`default_nettype wire
